// File: hw/rtl/dflm_pkg.sv
// Shared types and codes for the descriptor free-list manager.
package dflm_pkg;

	localparam int IndexW = 8;
	localparam int CountW = 9;

	localparam logic [CountW-1:0] MinQueue = 9'd2;
	localparam logic [CountW-1:0] ResetQueueSize = 9'd256;

	typedef enum logic [1:0] {
		KIND_INIT  = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_LINK  = 2'd2,
		KIND_FREE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_OVERRUN = 2'd2
	} status_t;

	// One table entry: link word and chain flag.
	typedef struct packed {
		logic [IndexW-1:0] link;
		logic              chain;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch_item;
		logic    do_init;
		logic    do_link;
		logic    load_cursor;
		logic    cursor_from_head;
		logic    rd_issue;
		logic    alloc_commit;
		logic    push_commit;
		logic    set_status;
		status_t status_code;
		logic    load_out;
	} dp_cmd_t;

	// Conditions reported by the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  list_empty;
		logic  cursor_oob;
		logic  entry_last;
		logic  step_limit;
	} dp_flags_t;

endpackage

// File: hw/rtl/dflm_datapath.sv
// Datapath: descriptor table memory, free-list head and count, walk cursor, result registers.
module dflm_datapath #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [8:0]               cfg_wr_data,
	input  logic [1:0]               kind,
	input  logic [7:0]               desc_index,
	input  logic [7:0]               next_index,
	input  logic                     has_next,
	input  dflm_pkg::dp_cmd_t        cmd,
	output dflm_pkg::dp_flags_t      flags,
	output logic [1:0]               status,
	output logic [7:0]               alloc_index,
	output logic [8:0]               free_count
);
	import dflm_pkg::*;

	localparam int TableDepth = (QUEUE_DEPTH < 256) ? QUEUE_DEPTH : 256;
	localparam int AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam logic [CountW-1:0] TableDepthC = CountW'(TableDepth);

	// Item and configuration registers
	kind_t               kind_q;
	logic [IndexW-1:0]   di_q;
	logic [IndexW-1:0]   ni_q;
	logic                hn_q;
	logic [CountW-1:0]   queue_size_q;

	// Free-list state and walk state
	logic [IndexW-1:0]   head_q;
	logic [CountW-1:0]   total_q;
	logic [IndexW-1:0]   cursor_q;
	logic [CountW-1:0]   step_q;
	status_t             status_q;
	logic [IndexW-1:0]   given_q;

	// Table storage
	entry_t              mem [TableDepth];
	logic [TableDepth-1:0] vld_q;
	entry_t              rd_word_q;
	logic                rd_vld_q;

	// Result registers
	status_t             out_status_q;
	logic [IndexW-1:0]   out_alloc_q;
	logic [CountW-1:0]   out_count_q;

	logic [CountW-1:0]   q_eff;
	logic [IndexW-1:0]   cur_link;
	logic                cur_chain;
	logic                mem_we;
	logic [AddrW-1:0]    mem_wa;
	entry_t              mem_wd;

	always_comb begin
		q_eff = queue_size_q;
		if (q_eff < MinQueue) begin
			q_eff = MinQueue;
		end
		if (q_eff > TableDepthC) begin
			q_eff = TableDepthC;
		end
	end

	// An entry never written since reset or init reads as its reset value.
	assign cur_link  = rd_vld_q ? rd_word_q.link : cursor_q + 8'd1;
	assign cur_chain = rd_vld_q & rd_word_q.chain;

	assign flags.kind       = kind_q;
	assign flags.list_empty = (total_q == '0) || ({1'b0, head_q} >= q_eff);
	assign flags.cursor_oob = {1'b0, cursor_q} >= q_eff;
	assign flags.entry_last = ~cur_chain;
	assign flags.step_limit = (step_q + 9'd1) == q_eff;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cursor_q[AddrW-1:0];
		mem_wd = '{link: '0, chain: 1'b0};
		if (cmd.do_link && ({1'b0, di_q} < q_eff)) begin
			mem_we = 1'b1;
			mem_wa = di_q[AddrW-1:0];
			mem_wd = '{link: ni_q, chain: hn_q};
		end else if (cmd.alloc_commit) begin
			mem_we = 1'b1;
		end else if (cmd.push_commit) begin
			mem_we = 1'b1;
			mem_wd = '{link: head_q, chain: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd_issue) begin
			rd_word_q <= mem[cursor_q[AddrW-1:0]];
			rd_vld_q  <= vld_q[cursor_q[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (cmd.do_init) begin
				for (int j = 0; j < TableDepth; j++) begin
					if (CountW'(j) < q_eff) begin
						vld_q[j] <= 1'b0;
					end
				end
			end else if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			kind_q <= kind_t'(kind);
			di_q   <= desc_index;
			ni_q   <= next_index;
			hn_q   <= has_next;
		end
		if (cmd.load_cursor) begin
			cursor_q <= cmd.cursor_from_head ? head_q : di_q;
			step_q   <= '0;
		end else if (cmd.push_commit) begin
			cursor_q <= cur_link;
			step_q   <= step_q + 9'd1;
		end
		if (cmd.latch_item) begin
			given_q <= '0;
		end else if (cmd.alloc_commit) begin
			given_q <= cursor_q;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_alloc_q  <= given_q;
			out_count_q  <= (total_q < q_eff) ? total_q : q_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_size_q <= ResetQueueSize;
			head_q       <= '0;
			total_q      <= TableDepthC;
			status_q     <= ST_OK;
		end else begin
			if (cfg_wr_en) begin
				queue_size_q <= cfg_wr_data;
			end
			if (cmd.latch_item) begin
				status_q <= ST_OK;
			end else if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.do_init) begin
				head_q  <= '0;
				total_q <= q_eff;
			end else if (cmd.alloc_commit) begin
				head_q  <= cur_link;
				total_q <= total_q - 9'd1;
			end else if (cmd.push_commit) begin
				head_q <= cursor_q;
				if (total_q < q_eff) begin
					total_q <= total_q + 9'd1;
				end
			end
		end
	end

	assign status      = out_status_q;
	assign alloc_index = out_alloc_q;
	assign free_count  = out_count_q;

endmodule

// File: hw/rtl/dflm_ctrl.sv
// Controller: sequences one item at a time through the datapath and owns the handshakes.
module dflm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  dflm_pkg::dp_flags_t  flags,
	output dflm_pkg::dp_cmd_t    cmd
);
	import dflm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_READ = 5'b00100,
		S_UPD  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = S_EXEC;
				end
			end
			S_EXEC: begin
				case (flags.kind)
					KIND_INIT: begin
						cmd.do_init = 1'b1;
						state_d     = S_FIN;
					end
					KIND_ALLOC: begin
						if (flags.list_empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
							state_d         = S_FIN;
						end else begin
							cmd.load_cursor      = 1'b1;
							cmd.cursor_from_head = 1'b1;
							state_d              = S_READ;
						end
					end
					KIND_LINK: begin
						cmd.do_link = 1'b1;
						state_d     = S_FIN;
					end
					KIND_FREE: begin
						cmd.load_cursor = 1'b1;
						state_d         = S_READ;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_READ: begin
				// Alloc cursor was range-checked with the head; only a walk can leave range.
				if (flags.kind == KIND_FREE && flags.cursor_oob) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_OVERRUN;
					state_d         = S_FIN;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = S_UPD;
				end
			end
			S_UPD: begin
				if (flags.kind == KIND_ALLOC) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_FIN;
				end else begin
					cmd.push_commit = 1'b1;
					if (flags.entry_last) begin
						state_d = S_FIN;
					end else if (flags.step_limit) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_OVERRUN;
						state_d         = S_FIN;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_FIN: begin
				// Hold the result until the output register frees up.
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/descriptor_free_list_manager_unit.sv
// Top level of the descriptor free-list manager for one split virtqueue.
//
// Input channel (in_valid / in_stall) carries one command item: kind selects
// init free list, allocate, set link or free chain; desc_index, next_index
// and has_next are its operands. The output channel (out_valid / out_stall)
// returns exactly one result item per command: status, alloc_index and
// free_count (free descriptors left, saturated at the effective queue size).
// queue_size is written via cfg_wr_en / cfg_wr_data, by the user only while idle; the
// block does not enforce this. It is clamped to 2..min(QUEUE_DEPTH, 256) on every command.
//
// Timing: one command is in flight at a time. Init, set link and an allocate that finds
// no free descriptor go from the execute state straight to finish; allocate passes
// through the read and update states, and a free chain through read and update once
// per pushed descriptor, with a final read when it stops at an index past the queue.
// Each link costs one registered read and one write-back in the single-port table.
// The result turns valid as the block returns to idle and sits in an output register,
// so a stalled receiver only blocks once a second result is ready.
//
// Reset: the table reads as entry i -> i+1 with chain flags clear (per-entry
// valid bits), the list head is 0 and the free count is min(256, QUEUE_DEPTH).
module descriptor_free_list_manager_unit #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] desc_index,
	input  logic [7:0] next_index,
	input  logic       has_next,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] alloc_index,
	output logic [8:0] free_count
);
	import dflm_pkg::*;

	dp_cmd_t   cmd;
	dp_flags_t flags;

	// Sequencer: walks each item through its states and drives the handshakes.
	dflm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	// Table, list head, free count, walk cursor and result registers.
	dflm_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.kind        (kind),
		.desc_index  (desc_index),
		.next_index  (next_index),
		.has_next    (has_next),
		.cmd         (cmd),
		.flags       (flags),
		.status      (status),
		.alloc_index (alloc_index),
		.free_count  (free_count)
	);

endmodule

// File: hw/rtl/dflm_checker.sv
// Port-level checks for the descriptor free-list manager, bound to the top level.
module dflm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] alloc_index,
	input logic [8:0] free_count
);
	import dflm_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(alloc_index) && $stable(free_count))
		else $error("result changed while stalled");

	// One command at a time: after an accept the input is stalled.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while busy");

	// Only a successful allocate hands out a nonzero index.
	a_index_ok_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> alloc_index == 8'd0)
		else $error("alloc_index set on failing command");

	// Status codes and count stay in range.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_OVERRUN)
			&& free_count <= 9'd256)
		else $error("result out of range");

	// A new result item only comes out of a cycle in which a command was being worked.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item appeared with no command in flight");

endmodule

bind descriptor_free_list_manager_unit dflm_checker u_dflm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.alloc_index (alloc_index),
	.free_count  (free_count)
);

// File: verif/descriptor_free_list_checker.sv
// Checker for the descriptor free-list manager: shadows the table and scores result items.
`timescale 1ns / 1ps
module descriptor_free_list_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] desc_index,
	input  logic [7:0] next_index,
	input  logic       has_next,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] status,
	input  logic [7:0] alloc_index,
	input  logic [8:0] free_count,
	output int         mismatches,
	output int         outstanding
);
	import dflm_pkg::*;

	localparam int Depth = 256;

	typedef struct {
		status_t    st;
		logic [7:0] idx;
		logic [8:0] cnt;
	} result_t;

	logic [7:0] link_word [Depth];
	logic       chain_bit [Depth];
	logic [7:0] list_head;
	int         free_total;
	logic [8:0] size_reg;
	result_t    pending_results [$];
	result_t    oldest;

	// Apply one command to the shadow table and queue the result it must produce.
	task automatic track_command(input kind_t k, input logic [7:0] di, input logic [7:0] ni,
			input logic hn);
		int         q;
		int         cur;
		int         step;
		logic [7:0] nxt;
		logic       last;
		bit         done;
		result_t    r;
		q = (size_reg < 9'd2) ? 2 : int'(size_reg);
		if (q > Depth)
			q = Depth;
		r.st = ST_OK;
		r.idx = '0;
		case (k)
		KIND_INIT: begin
			for (int i = 0; i < q; i++) begin
				link_word[i] = 8'(i + 1);
				chain_bit[i] = 1'b0;
			end
			list_head = '0;
			free_total = q;
		end
		KIND_ALLOC: begin
			if (free_total == 0 || int'(list_head) >= q) begin
				r.st = ST_EMPTY;
			end else begin
				r.idx = list_head;
				list_head = link_word[r.idx];
				free_total--;
				link_word[r.idx] = '0;
				chain_bit[r.idx] = 1'b0;
			end
		end
		KIND_LINK: begin
			if (int'(di) < q) begin
				link_word[di] = ni;
				chain_bit[di] = hn;
			end
		end
		default: begin
			cur = int'(di);
			done = 1'b0;
			for (step = 0; step < q && !done; step++) begin
				if (cur >= q) begin
					r.st = ST_OVERRUN;
					done = 1'b1;
				end else begin
					nxt = link_word[cur];
					last = !chain_bit[cur];
					link_word[cur] = list_head;
					chain_bit[cur] = 1'b0;
					list_head = 8'(cur);
					if (free_total < q)
						free_total++;
					if (last)
						done = 1'b1;
					else
						cur = int'(nxt);
				end
			end
			if (!done)
				r.st = ST_OVERRUN;
		end
		endcase
		r.cnt = 9'((free_total < q) ? free_total : q);
		pending_results.push_back(r);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < Depth; i++) begin
				link_word[i] = 8'(i + 1);
				chain_bit[i] = 1'b0;
			end
			list_head = '0;
			size_reg = ResetQueueSize;
			free_total = 256;
			pending_results.delete();
		end else begin
			// Score the result first: it always belongs to an older command.
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result item with no command waiting");
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					if (status !== oldest.st) begin
						$error("status: expected %0d, got %0d", oldest.st, status);
						mismatches++;
					end
					if (alloc_index !== oldest.idx) begin
						$error("alloc_index: expected %0d, got %0d", oldest.idx, alloc_index);
						mismatches++;
					end
					if (free_count !== oldest.cnt) begin
						$error("free_count: expected %0d, got %0d", oldest.cnt, free_count);
						mismatches++;
					end
				end
			end
			if (cfg_wr_en)
				size_reg = cfg_wr_data;
			if (in_valid && !in_stall)
				track_command(kind_t'(kind), desc_index, next_index, has_next);
		end
		outstanding = pending_results.size();
	end

endmodule

// File: verif/descriptor_free_list_manager_unit_tb.sv
// Testbench top for the descriptor free-list manager: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module descriptor_free_list_manager_unit_tb;
	import dflm_pkg::*;

	// Cycles with no handshake on either channel before the run is declared hung.
	// It must outlast a full-length walk and the long receiver hold-off.
	localparam int WatchdogLimit = 5000;
	localparam int HoldCycles = 300;
	localparam int ItemsPerPhase = 156;
	localparam int Phases = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       cfg_wr_en;
	logic [8:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic [7:0] desc_index;
	logic [7:0] next_index;
	logic       has_next;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] status;
	logic [7:0] alloc_index;
	logic [8:0] free_count;

	int mismatches;
	int outstanding;

	// Stimulus knobs, shared with the receiver process.
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// Kinds of accepted commands whose result has not come back, and the
	// descriptors the stimulus currently holds from successful allocations.
	kind_t      issued_kinds [$];
	logic [7:0] held_descs [$];

	// Requested sizes per random phase; entry 10 is replaced by a random value.
	logic [8:0] phase_sizes [Phases] = '{9'd256, 9'd3, 9'd511, 9'd1, 9'd16, 9'd257,
		9'd255, 9'd64, 9'd2, 9'd128, 9'd0, 9'd32};

	descriptor_free_list_manager_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.desc_index  (desc_index),
		.next_index  (next_index),
		.has_next    (has_next),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.alloc_index (alloc_index),
		.free_count  (free_count)
	);

	descriptor_free_list_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.desc_index  (desc_index),
		.next_index  (next_index),
		.has_next    (has_next),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.alloc_index (alloc_index),
		.free_count  (free_count),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall at random, or hold off for a long counted stretch when
	// the stimulus asks for it so the block backs up into its input.
	initial begin
		int hold_taken;
		hold_taken = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_taken < hold_reqs) begin
				hold_taken++;
				out_stall <= 1'b1;
				repeat (HoldCycles - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Track returned results so chains are built only from descriptors we own.
	// An init result wipes ownership: everything went back to the free list.
	always @(posedge clk) begin
		kind_t done_kind;
		if (arst_n && out_valid && !out_stall && issued_kinds.size() != 0) begin
			done_kind = issued_kinds.pop_front();
			if (done_kind == KIND_INIT)
				held_descs.delete();
			else if (done_kind == KIND_ALLOC && status == ST_OK)
				held_descs.push_back(alloc_index);
		end
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WatchdogLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one command item, with a random gap first; return at the falling
	// edge after acceptance with valid still high, so the next call or a
	// sync decides its level in a single assignment.
	task automatic send(input kind_t k, input logic [7:0] di, input logic [7:0] ni,
			input logic hn);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		desc_index <= di;
		next_index <= ni;
		has_next <= hn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		issued_kinds.push_back(k);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every result is back.
	task automatic sync_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (issued_kinds.size() != 0);
	endtask

	// Drain, then give the block time to retire its output register.
	task automatic settle();
		sync_results();
		repeat (4) @(negedge clk);
	endtask

	task automatic write_size(input logic [8:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_noise();
		kind_t k;
		k = ($urandom_range(0, 15) == 0) ? KIND_INIT : kind_t'($urandom_range(1, 3));
		send(k, 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// Link a few owned descriptors into a chain and free it. Now and then
	// leave the tail flagged so the walk runs on, or free from the middle.
	task automatic chain_and_free();
		logic [7:0] chain [$];
		int         len;
		int         pick;
		sync_results();
		if (held_descs.size() == 0)
			return;
		len = $urandom_range(1, (held_descs.size() < 5) ? held_descs.size() : 5);
		for (int j = 0; j < len; j++) begin
			pick = $urandom_range(0, held_descs.size() - 1);
			chain.push_back(held_descs[pick]);
			held_descs.delete(pick);
		end
		for (int j = 0; j < len - 1; j++)
			send(KIND_LINK, chain[j], chain[j + 1], 1'b1);
		send(KIND_LINK, chain[len - 1], 8'($urandom), ($urandom_range(0, 9) == 0));
		pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : 0;
		send(KIND_FREE, chain[pick], 8'($urandom), 1'($urandom));
	endtask

	initial begin
		int  phase_start;
		int  roll;
		bit  pressed;

		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		kind = KIND_INIT;
		desc_index = '0;
		next_index = '0;
		has_next = 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: full-size table, a two-entry loop whose walk stops when it
		// comes back to an entry it already freed, and the top index as a
		// one-entry chain.
		send(KIND_INIT, 8'd0, 8'd0, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_LINK, 8'd0, 8'd1, 1'b1);
		send(KIND_LINK, 8'd1, 8'd0, 1'b1);
		send(KIND_FREE, 8'd0, 8'd0, 1'b0);
		send(KIND_LINK, 8'd255, 8'd255, 1'b0);
		send(KIND_FREE, 8'd255, 8'd0, 1'b0);

		// Size 16: corrupt the free head's link so a later allocate finds a
		// head past the queue, link out of range, walk off the table, and
		// push an already free descriptor against the saturated count.
		settle();
		write_size(9'd16);
		send(KIND_INIT, 8'd0, 8'd0, 1'b0);
		send(KIND_LINK, 8'd0, 8'd200, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_LINK, 8'd200, 8'd3, 1'b1);
		send(KIND_LINK, 8'd0, 8'd250, 1'b1);
		send(KIND_FREE, 8'd0, 8'd0, 1'b0);
		send(KIND_FREE, 8'd255, 8'd0, 1'b0);
		send(KIND_FREE, 8'd5, 8'd0, 1'b0);

		// Size below minimum: the count from the larger queue reads clamped,
		// then drain the two-entry list until it is empty.
		settle();
		write_size(9'd0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_INIT, 8'd0, 8'd0, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);
		send(KIND_FREE, 8'd1, 8'd0, 1'b0);

		// Oversized request clamps back to the full table.
		settle();
		write_size(9'h1FF);
		send(KIND_ALLOC, 8'd0, 8'd0, 1'b0);

		// Random phases: each picks a size and an idling pattern, mostly runs
		// allocate / link / free sequences, and sprinkles raw noise.
		for (int ph = 0; ph < Phases; ph++) begin
			settle();
			write_size((ph == 10) ? 9'($urandom) : phase_sizes[ph]);
			case (ph % 4)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 62;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 62;
			end
			default: begin
				idle_pct = 37;
				stall_pct = 37;
			end
			endcase
			// Skip the init now and then so a resized queue runs on stale state.
			if ($urandom_range(0, 4) != 0)
				send(KIND_INIT, 8'($urandom), 8'($urandom), 1'($urandom));
			phase_start = items_sent;
			pressed = 1'b0;
			while (items_sent - phase_start < ItemsPerPhase) begin
				if (ph % 5 == 2 && !pressed && items_sent - phase_start > ItemsPerPhase / 2) begin
					// Hold off the receiver and keep offering items until the
					// block backs up and stalls its input.
					pressed = 1'b1;
					hold_reqs++;
					repeat (8) send(KIND_ALLOC, 8'($urandom), 8'($urandom), 1'($urandom));
				end
				roll = $urandom_range(0, 99);
				if (roll < 20)
					random_noise();
				else if (roll < 55 || held_descs.size() == 0)
					repeat ($urandom_range(1, 4))
						send(KIND_ALLOC, 8'($urandom), 8'($urandom), 1'($urandom));
				else
					chain_and_free();
			end
		end

		settle();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			if (outstanding != 0)
				$error("%0d result items never arrived", outstanding);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
